@@ sv/ttcg_pkg.sv @@
// Shared types, constants and command structures for the truncated triangle centroid block.
package ttcg_pkg;

   localparam int FRAC_BITS = 16;
   localparam int ONE_W     = FRAC_BITS + 2;
   localparam logic [16:0] ONE_F = 17'(1 << FRAC_BITS);

   localparam logic [1:0] REQ_EVAL  = 2'd0;
   localparam logic [1:0] REQ_ACCUM = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [1:0] CSR_LOW  = 2'd0;
   localparam logic [1:0] CSR_CORE = 2'd1;
   localparam logic [1:0] CSR_HIGH = 2'd2;

   localparam logic [1:0] DIV_SEL_Q = 2'd0;
   localparam logic [1:0] DIV_SEL_A = 2'd1;
   localparam logic [1:0] DIV_SEL_B = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV_Q,
      ST_DIV_A,
      ST_DIV_B,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_FINISH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic div_start;
      logic [1:0] div_sel;
      logic div_step;
      logic mul1;
      logic mul2;
      logic mul3;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic       div_done;
      logic [1:0] req_type;
   } status_type;

endpackage

@@ sv/ttcg_ctrl.sv @@
// Controller state machine sequencing the shared divider and multiplier steps.
module ttcg_ctrl
   import ttcg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep      = 1'b1;
            cmd.div_start = 1'b1;
            if (status.req_type == REQ_EVAL) begin
               cmd.div_sel = DIV_SEL_Q;
               state_in    = ST_DIV_Q;
            end else if (status.req_type == REQ_ACCUM) begin
               cmd.div_sel = DIV_SEL_A;
               state_in    = ST_DIV_A;
            end else begin
               cmd.div_start = 1'b0;
               state_in      = ST_FINISH;
            end
         end
         ST_DIV_Q: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_MUL1;
            end
         end
         ST_DIV_A: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SEL_B;
               state_in      = ST_DIV_B;
            end
         end
         ST_DIV_B: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.mul3 = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ sv/ttcg_dp.sv @@
// Datapath: configuration registers, divider, multiplier steps and saturating accumulators.
module ttcg_dp
   import ttcg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic [1:0]         req_type,
   input  logic [16:0]        req_firing,
   input  logic signed [31:0] req_grad_weight,
   input  logic signed [31:0] req_grad_position,
   input  cmd_type            cmd,
   output status_type         status,
   output logic signed [31:0] rsp_area_weight,
   output logic signed [31:0] rsp_centroid,
   output logic signed [47:0] rsp_acc_low,
   output logic signed [47:0] rsp_acc_core,
   output logic signed [47:0] rsp_acc_high
);

   localparam int NUM_W = 2 * ONE_W + 2;
   localparam int DEN_W = ONE_W + 2;
   localparam int QUO_W = ONE_W;
   localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};
   localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] I32_MIN = -64'sd2147483648;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);
   // Reciprocal of three scaled by 2^34; exact for dividends below 2^33.
   localparam logic [33:0] RECIP3 = 34'd5726623062;

   logic signed [31:0] low_ff, core_ff, high_ff;
   logic [1:0]         type_ff;
   logic [16:0]        f_ff;
   logic signed [31:0] gw_ff, gy_ff;
   logic [ONE_W-1:0]   k_ff, q_ff, a_ff, b_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [NUM_W-1:0]   rem_ff;
   logic [QUO_W-1:0]   quo_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [1:0]         dsel_ff;
   logic signed [63:0] p1_ff, p2_ff, p3_ff;
   logic signed [63:0] third_ff;
   logic [50:0]        tlo_ff;
   logic signed [31:0] area_ff, cen_ff;
   logic signed [47:0] acc_low_ff, acc_core_ff, acc_high_ff;

   function automatic logic signed [63:0] rnd(input logic signed [63:0] x);
      logic [63:0] u;
      logic [63:0] r;
      u = x[63] ? 64'(-x) : 64'(x);
      r = (u + 64'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return x[63] ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic signed [47:0] acc_add(input logic signed [47:0] acc,
                                                  input logic signed [63:0] d);
      logic signed [63:0] s;
      s = 64'(acc) + d;
      if (s > 64'(ACC_MAX)) return ACC_MAX;
      else if (s < 64'(ACC_MIN)) return ACC_MIN;
      else return s[47:0];
   endfunction

   logic [16:0]      f_sat;
   logic [ONE_W-1:0] twominus;
   logic [NUM_W-1:0] num_sel;
   logic [DEN_W-1:0] den3;
   logic [NUM_W-1:0] rem_shift;
   logic [NUM_W-1:0] den_ext;
   logic [ONE_W-1:0] g;
   logic [2*ONE_W-1:0] fk;
   logic signed [63:0] s3;
   logic [63:0] su;
   logic [33:0] su1;
   logic [66:0] tfull;
   logic [63:0] thr;

   assign f_sat    = (req_firing > ONE_F) ? ONE_F : req_firing;
   assign twominus = ONE_W'(2 * ONE_F) - ONE_W'(f_ff);
   assign den3     = DEN_W'(3) * DEN_W'(twominus);
   assign g        = ONE_W'(ONE_F) - ONE_W'(f_ff);
   assign fk       = (2*ONE_W)'(f_ff) * (2*ONE_W)'(twominus);
   assign s3       = 64'(low_ff) + 64'(core_ff) + 64'(high_ff);
   assign su       = s3[63] ? 64'(-s3) : 64'(s3);
   assign su1      = su[33:0] + 34'd1;
   assign tfull    = (67'(51'(su1) * 51'(RECIP3[33:17])) << 17) + 67'(tlo_ff);
   assign thr      = 64'(tfull[66:34]);

   always_comb begin
      unique case (cmd.div_sel)
         DIV_SEL_Q: num_sel = NUM_W'((2*ONE_W)'(g) * (2*ONE_W)'(g));
         DIV_SEL_A: num_sel = NUM_W'(3) * NUM_W'(ONE_F) * NUM_W'(ONE_F)
                       - NUM_W'(3) * NUM_W'(f_ff) * NUM_W'(ONE_F)
                       + NUM_W'(f_ff) * NUM_W'(f_ff);
         default: num_sel = NUM_W'(f_ff) * (NUM_W'(3) * NUM_W'(ONE_F) - NUM_W'(2) * NUM_W'(f_ff));
      endcase
   end

   assign den_ext   = NUM_W'(den_ff);
   assign rem_shift = {rem_ff[NUM_W-2:0], num_ff[NUM_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff      <= 32'sd0;
         core_ff     <= 32'sd32768;
         high_ff     <= 32'sd65536;
         acc_low_ff  <= '0;
         acc_core_ff <= '0;
         acc_high_ff <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_LOW:  low_ff  <= csr_data;
               CSR_CORE: core_ff <= csr_data;
               CSR_HIGH: high_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.finish) begin
            if (type_ff == REQ_ACCUM) begin
               acc_low_ff  <= acc_add(acc_low_ff, rnd(p2_ff - p1_ff));
               acc_high_ff <= acc_add(acc_high_ff, rnd(p2_ff + p1_ff));
               acc_core_ff <= acc_add(acc_core_ff, rnd(p3_ff));
            end else if (type_ff == REQ_CLEAR) begin
               acc_low_ff  <= '0;
               acc_core_ff <= '0;
               acc_high_ff <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= req_type;
         f_ff    <= f_sat;
         gw_ff   <= req_grad_weight;
         gy_ff   <= req_grad_position;
      end
      if (cmd.prep) begin
         k_ff     <= ONE_W'((fk + (2*ONE_W)'(1 << FRAC_BITS)) >> (FRAC_BITS + 1));
         den_ff   <= den3;
      end
      if (cmd.div_start) begin
         num_ff  <= num_sel + NUM_W'(cmd.prep ? den3 >> 1 : den_ff >> 1);
         rem_ff  <= '0;
         quo_ff  <= '0;
         cnt_ff  <= DIV_CNT_W'(NUM_W);
         dsel_ff <= cmd.div_sel;
      end else if (cmd.div_step && cnt_ff != '0) begin
         num_ff <= {num_ff[NUM_W-2:0], 1'b0};
         cnt_ff <= cnt_ff - 1'b1;
         if (rem_shift >= den_ext) begin
            rem_ff <= rem_shift - den_ext;
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift;
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
         end
      end
      if (cmd.div_step && cnt_ff == '0) begin
         unique case (dsel_ff)
            DIV_SEL_Q: q_ff <= quo_ff;
            DIV_SEL_A: a_ff <= quo_ff;
            default:   b_ff <= quo_ff;
         endcase
      end
      if (cmd.mul1) begin
         tlo_ff <= 51'(su1) * 51'(RECIP3[16:0]);
         if (type_ff == REQ_EVAL) begin
            p1_ff <= (64'(high_ff) - 64'(low_ff)) * $signed({1'b0, k_ff});
         end else begin
            p1_ff <= 64'(gw_ff) * $signed({1'b0, k_ff});
         end
      end
      if (cmd.mul2) begin
         third_ff <= s3[63] ? -$signed(thr) : $signed(thr);
         if (type_ff == REQ_EVAL) begin
            p2_ff <= (2 * 64'(core_ff) - 64'(low_ff) - 64'(high_ff)) * $signed({1'b0, q_ff});
         end else begin
            p2_ff <= 64'(gy_ff) * $signed({1'b0, a_ff});
         end
      end
      if (cmd.mul3) begin
         p3_ff <= 64'(gy_ff) * $signed({1'b0, b_ff});
         if (type_ff == REQ_EVAL) begin
            if (rnd(p1_ff) > I32_MAX) area_ff <= I32_MAX[31:0];
            else if (rnd(p1_ff) < I32_MIN) area_ff <= I32_MIN[31:0];
            else area_ff <= 32'(rnd(p1_ff));
         end else begin
            area_ff <= '0;
         end
      end
      if (cmd.finish) begin
         if (type_ff == REQ_EVAL && area_ff != '0) begin
            if (third_ff - rnd(p2_ff) > I32_MAX) cen_ff <= I32_MAX[31:0];
            else if (third_ff - rnd(p2_ff) < I32_MIN) cen_ff <= I32_MIN[31:0];
            else cen_ff <= 32'(third_ff - rnd(p2_ff));
         end else begin
            cen_ff <= '0;
         end
         if (type_ff != REQ_EVAL) begin
            area_ff <= '0;
         end
      end
   end

   assign status.div_done = (cnt_ff == '0);
   assign status.req_type = type_ff;

   assign rsp_area_weight = area_ff;
   assign rsp_centroid    = cen_ff;
   assign rsp_acc_low     = acc_low_ff;
   assign rsp_acc_core    = acc_core_ff;
   assign rsp_acc_high    = acc_high_ff;

endmodule

@@ sv/truncated_triangle_centroid_grad.sv @@
// Top level of the truncated triangle centroid and gradient block.
// Channel   Direction  Ports
// request   in         req_valid, req_ready, req_type, req_firing, req_grad_*
// response  out        rsp_valid, rsp_ready, rsp_area_weight, rsp_centroid, rsp_acc_*
// csr       in         csr_write, csr_index, csr_data
// One transaction at a time; each evaluate request runs one quotient and each accumulate request
// two on the one-bit-per-cycle restoring divider shared for all quotients; clear or an unused
// type skips the divider.
// Synchronous reset restores the triangle registers and clears the accumulators.
// The response is held until rsp_ready; no request is taken meanwhile.
module truncated_triangle_centroid_grad
   import ttcg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [16:0]        req_firing,
   input  logic signed [31:0] req_grad_weight,
   input  logic signed [31:0] req_grad_position,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_area_weight,
   output logic signed [31:0] rsp_centroid,
   output logic signed [47:0] rsp_acc_low,
   output logic signed [47:0] rsp_acc_core,
   output logic signed [47:0] rsp_acc_high
);

   cmd_type    cmd;
   status_type status;

   ttcg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ttcg_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_type          (req_type),
      .req_firing        (req_firing),
      .req_grad_weight   (req_grad_weight),
      .req_grad_position (req_grad_position),
      .cmd               (cmd),
      .status            (status),
      .rsp_area_weight   (rsp_area_weight),
      .rsp_centroid      (rsp_centroid),
      .rsp_acc_low       (rsp_acc_low),
      .rsp_acc_core      (rsp_acc_core),
      .rsp_acc_high      (rsp_acc_high)
   );

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the truncated triangle centroid and gradient block.
`timescale 1ns / 100ps

module testbench
   import ttcg_pkg::*;
();

   localparam longint ACC_HI = (64'sd1 <<< 47) - 1;
   localparam longint ACC_LO = -(64'sd1 <<< 47);
   localparam longint ONE    = 64'sd1 <<< FRAC_BITS;

   typedef struct {
      logic signed [31:0] area;
      logic signed [31:0] cen;
      logic signed [47:0] lo;
      logic signed [47:0] co;
      logic signed [47:0] hi;
   } centroid_result_type;

   class centroid_scoreboard_type;
      longint tri_low, tri_core, tri_high;
      longint grad_low, grad_core, grad_high;
      centroid_result_type pending[$];
      int errors;

      function new();
         tri_low = 0; tri_core = 32768; tri_high = 65536;
         grad_low = 0; grad_core = 0; grad_high = 0;
         errors = 0;
      endfunction

      function longint round_shift(longint x, int s);
         longint u;
         u = (x < 0) ? -x : x;
         u = (u + (64'sd1 <<< (s - 1))) >>> s;
         return (x < 0) ? -u : u;
      endfunction

      function longint clamp(longint x, longint lo, longint hi);
         return x < lo ? lo : (x > hi ? hi : x);
      endfunction

      function void set_register(logic [1:0] idx, logic [31:0] val);
         longint v;
         v = longint'(signed'(val));
         case (idx)
            CSR_LOW: tri_low = v;
            CSR_CORE: tri_core = v;
            CSR_HIGH: tri_high = v;
            default: ;
         endcase
      endfunction

      function void note_request(logic [1:0] kind, logic [16:0] fire,
                                 logic signed [31:0] gw_in, logic signed [31:0] gy_in);
         centroid_result_type r;
         longint f, tm, d3, k, g, q, s, su, third, t, a, b, gw, gy;
         f = fire;
         if (f > ONE) f = ONE;
         gw = gw_in;
         gy = gy_in;
         tm = 2 * ONE - f;
         d3 = 3 * tm;
         k = round_shift(f * tm, FRAC_BITS + 1);
         r.area = 0;
         r.cen = 0;
         if (kind == REQ_EVAL) begin
            g = ONE - f;
            q = (g * g + d3 / 2) / d3;
            s = tri_low + tri_core + tri_high;
            su = (s < 0) ? -s : s;
            third = (su + 1) / 3;
            if (s < 0) third = -third;
            r.area = 32'(clamp(round_shift((tri_high - tri_low) * k, FRAC_BITS),
                               -64'sd2147483648, 64'sd2147483647));
            if (r.area != 0) begin
               t = round_shift((2 * tri_core - tri_low - tri_high) * q, FRAC_BITS);
               r.cen = 32'(clamp(third - t, -64'sd2147483648, 64'sd2147483647));
            end
         end else if (kind == REQ_ACCUM) begin
            a = (3 * ONE * ONE - 3 * f * ONE + f * f + d3 / 2) / d3;
            b = (f * (3 * ONE - 2 * f) + d3 / 2) / d3;
            grad_low = clamp(grad_low + round_shift(gy * a - gw * k, FRAC_BITS),
                             ACC_LO, ACC_HI);
            grad_core = clamp(grad_core + round_shift(gy * b, FRAC_BITS), ACC_LO, ACC_HI);
            grad_high = clamp(grad_high + round_shift(gy * a + gw * k, FRAC_BITS),
                              ACC_LO, ACC_HI);
         end else if (kind == REQ_CLEAR) begin
            grad_low = 0; grad_core = 0; grad_high = 0;
         end
         r.lo = 48'(grad_low);
         r.co = 48'(grad_core);
         r.hi = 48'(grad_high);
         pending.push_back(r);
      endfunction

      function void check_response(centroid_result_type got);
         centroid_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response area %0d", $time, got.area);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.area !== e.area) begin
            $display("%0t: area expected %0d actual %0d", $time, e.area, got.area);
            errors++;
         end
         if (got.cen !== e.cen) begin
            $display("%0t: centroid expected %0d actual %0d", $time, e.cen, got.cen);
            errors++;
         end
         if (got.lo !== e.lo) begin
            $display("%0t: acc_low expected %0d actual %0d", $time, e.lo, got.lo);
            errors++;
         end
         if (got.co !== e.co) begin
            $display("%0t: acc_core expected %0d actual %0d", $time, e.co, got.co);
            errors++;
         end
         if (got.hi !== e.hi) begin
            $display("%0t: acc_high expected %0d actual %0d", $time, e.hi, got.hi);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               csr_write = 0;
   logic [1:0]         csr_index = CSR_LOW;
   logic [31:0]        csr_data = 0;
   logic               req_valid = 0;
   logic               req_ready;
   logic [1:0]         req_type = REQ_EVAL;
   logic [16:0]        req_firing = 0;
   logic signed [31:0] req_grad_weight = 0;
   logic signed [31:0] req_grad_position = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic signed [31:0] rsp_area_weight, rsp_centroid;
   logic signed [47:0] rsp_acc_low, rsp_acc_core, rsp_acc_high;

   centroid_scoreboard_type board = new();
   bit hold_off = 0;
   bit stimulus_done = 0;

   truncated_triangle_centroid_grad uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic write_register(logic [1:0] idx, logic [31:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      board.set_register(idx, val);
      @(posedge clock);
      csr_write <= 0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic send_request(logic [1:0] kind, logic [16:0] fire,
                               logic [31:0] gw, logic [31:0] gy);
      req_valid <= 1;
      req_type <= kind;
      req_firing <= fire;
      req_grad_weight <= gw;
      req_grad_position <= gy;
      do @(posedge clock); while (!req_ready);
      board.note_request(kind, fire, gw, gy);
   endtask

   function automatic logic [31:0] any_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'($urandom_range(0, 262144)) - 32'd131072;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [16:0] any_firing();
      case ($urandom_range(0, 7))
         0: return 17'd0;
         1: return ONE_F;
         2: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic random_burst(int count);
      int gap;
      logic [1:0] kind;
      for (int i = 0; i < count; i++) begin
         gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 60) : 0;
         if (gap != 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
         case ($urandom_range(0, 19))
            0: kind = REQ_CLEAR;
            1: kind = 2'd3;
            2, 3, 4, 5, 6, 7, 8, 9: kind = REQ_ACCUM;
            default: kind = REQ_EVAL;
         endcase
         send_request(kind, any_firing(), any_word(), any_word());
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (hold_off) rsp_ready <= 0;
         else case ($urandom_range(0, 15))
            0, 1, 2: rsp_ready <= 0;
            3: rsp_ready <= ($urandom_range(0, 1) == 1);
            default: rsp_ready <= 1;
         endcase
      end
   end

   always @(posedge clock) begin
      centroid_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.area = rsp_area_weight;
         got.cen = rsp_centroid;
         got.lo = rsp_acc_low;
         got.co = rsp_acc_core;
         got.hi = rsp_acc_high;
         board.check_response(got);
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part on the reset, extreme, inverted and flat triangles.
      send_request(REQ_EVAL, 17'd0, 0, 0);
      send_request(REQ_EVAL, ONE_F, 0, 0);
      send_request(REQ_EVAL, 17'h1ffff, 0, 0);
      send_request(REQ_EVAL, 17'd32768, 0, 0);
      send_request(REQ_ACCUM, 17'd0, 32'h7fffffff, 32'h80000000);
      send_request(REQ_ACCUM, ONE_F, 32'h80000000, 32'h7fffffff);
      send_request(REQ_ACCUM, 17'h1ffff, 32'hffffffff, 32'hffffffff);
      send_request(2'd3, 17'h1ffff, 32'hffffffff, 32'hffffffff);
      send_request(REQ_CLEAR, 17'd100, 32'd5, 32'd7);
      wait_idle();
      write_register(CSR_LOW, 32'h80000000);
      write_register(CSR_CORE, 32'h00000000);
      write_register(CSR_HIGH, 32'h7fffffff);
      send_request(REQ_EVAL, ONE_F, 0, 0);
      send_request(REQ_EVAL, 17'd1, 0, 0);
      send_request(REQ_EVAL, 17'd40000, 0, 0);
      wait_idle();
      write_register(CSR_LOW, 32'h7fffffff);
      write_register(CSR_CORE, 32'h80000000);
      write_register(CSR_HIGH, 32'h80000000);
      send_request(REQ_EVAL, ONE_F, 0, 0);
      send_request(REQ_EVAL, 17'd20000, 0, 0);
      wait_idle();
      write_register(CSR_LOW, 32'd65536);
      write_register(CSR_CORE, 32'd65536);
      write_register(CSR_HIGH, 32'd65536);
      send_request(REQ_EVAL, 17'd30000, 0, 0);
      for (int i = 0; i < 40; i++)
         send_request(REQ_ACCUM, ONE_F, 32'h7fffffff, 32'h7fffffff);
      for (int i = 0; i < 40; i++)
         send_request(REQ_ACCUM, ONE_F, 32'h80000000, 32'h80000000);

      for (int phase = 0; phase < 8; phase++) begin
         wait_idle();
         if (phase % 2 == 0) begin
            write_register(CSR_LOW, -32'sd131072 + 32'($urandom_range(0, 131072)));
            write_register(CSR_CORE, 32'($urandom_range(0, 131072)) - 32'sd65536);
            write_register(CSR_HIGH, 32'($urandom_range(0, 131072)));
         end else begin
            write_register(CSR_LOW, any_word());
            write_register(CSR_CORE, any_word());
            write_register(CSR_HIGH, any_word());
         end
         if (phase == 3) begin
            fork
               begin
                  hold_off = 1;
                  repeat (600) @(posedge clock);
                  hold_off = 0;
               end
               random_burst(20);
            join
         end else
            random_burst(112);
      end
      req_valid <= 0;
      stimulus_done = 1;
   end

   initial begin
      wait (stimulus_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("testbench: done, errors");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/ttcg_pkg.sv
sv/ttcg_ctrl.sv
sv/ttcg_dp.sv
sv/truncated_triangle_centroid_grad.sv
bench/testbench.sv
